// File: rtl/core/rtd_pkg.sv
// Shared constants, types and helpers for the RLE RGB555 texture decoder.
package rtd_pkg;

  // Image geometry and field widths
  localparam int IMAGE_PIXELS = 16384;
  localparam int WORD_W       = 16;
  localparam int COLOR_W      = 32;
  localparam int COUNT_W      = 15;
  localparam int RUN_W        = 16;
  localparam int PIX_W        = $clog2(IMAGE_PIXELS + 1);
  localparam int CMP_W        = (PIX_W > RUN_W) ? PIX_W : RUN_W;

  // Configuration port
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_COMPRESSED_MODE = '0;

  // Word codes
  localparam logic [7:0] LITERAL_TAG = 8'hFF;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Decoder phase, one-hot
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b000_0001,
    PH_SKIP    = 7'b000_0010,
    PH_CTRL    = 7'b000_0100,
    PH_REPEAT  = 7'b000_1000,
    PH_LITERAL = 7'b001_0000,
    PH_RAW     = 7'b010_0000,
    PH_DONE    = 7'b100_0000
  } phase_e;

  // Registered input item handed to the decode stage
  typedef struct packed {
    logic              valid;
    logic              start_req;
    logic [WORD_W-1:0] word;
  } rtd_item_t;

  // Repack RGB555 to ARGB8888, bit 15 dropped
  function automatic logic [COLOR_W-1:0] to_argb(input logic [WORD_W-1:0] w);
    return {ALPHA_OPAQUE, w[14:10], 3'b000, w[9:5], 3'b000, w[4:0], 3'b000};
  endfunction

endpackage

// File: rtl/core/rtd_if.sv
// Valid/ready stream interfaces for texture words and decoded runs.
interface rtd_in_if import rtd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              start_req;
  logic [WORD_W-1:0] word;

  modport source (output valid, output start_req, output word, input ready);
  modport sink   (input valid, input start_req, input word, output ready);
endinterface

interface rtd_out_if import rtd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;
  logic [COUNT_W-1:0] count;
  logic               last;

  modport source (output valid, output color, output count, output last, input ready);
  modport sink   (input valid, input color, input count, input last, output ready);
endinterface

// File: rtl/core/rtd_cfg.sv
// APB configuration register block holding the compressed-mode bit.
module rtd_cfg import rtd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  compressed_mode_o
);

  logic mode_q;
  logic mode_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_COMPRESSED_MODE);

  // Take the new mode on a completed write
  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Read back
  assign prdata = (paddr == REG_COMPRESSED_MODE) ? APB_DATA_W'(mode_q) : '0;
  assign compressed_mode_o = mode_q;

endmodule

// File: rtl/core/rtd_in_stage.sv
// Input register before decode: takes one texture word per cycle unless stalled.
module rtd_in_stage import rtd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtd_in_if.sink     in_i,
  input  logic       advance_i,
  output rtd_item_t  item_o
);

  logic              valid_q;
  logic              valid_d;
  logic              start_q;
  logic [WORD_W-1:0] word_q;
  logic              ready;
  logic              accept;

  // Free when empty or when the held word moves on this cycle
  assign ready       = !valid_q || advance_i;
  assign in_i.ready  = ready;
  assign accept      = in_i.valid && ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on each transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q <= in_i.start_req;
      word_q  <= in_i.word;
    end
  end

  assign item_o = '{valid: valid_q, start_req: start_q, word: word_q};

endmodule

// File: rtl/core/rtd_decode.sv
// Decode stage: run-length state update, pixel repack, clamp and result register.
module rtd_decode import rtd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       compressed_mode_i,
  input  rtd_item_t  item_i,
  output logic       advance_o,
  rtd_out_if.source  out_o
);

  phase_e             phase_q, phase_d;
  logic [1:0]         skip_q, skip_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [PIX_W-1:0]   pixels_q, pixels_d;

  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] color_q;
  logic [COUNT_W-1:0] count_q;
  logic               last_q;

  logic               advance;
  logic               emit;
  logic [RUN_W-1:0]   emit_n;
  logic [PIX_W-1:0]   base;
  logic [PIX_W-1:0]   remaining;
  logic [CMP_W-1:0]   clamp_n;
  logic [PIX_W-1:0]   done_next;
  logic               last;

  // Move the held word when the result register can take its outcome
  assign advance   = item_i.valid && (!out_valid_q || out_o.ready);
  assign advance_o = advance;

  // Next state and emit decision
  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    run_d   = run_q;
    emit    = 1'b0;
    emit_n  = RUN_W'(1);
    if (item_i.start_req) begin
      run_d = '0;
      if (compressed_mode_i) begin
        skip_d  = 2'd1;
        phase_d = PH_SKIP;
      end else begin
        skip_d  = 2'd0;
        phase_d = PH_RAW;
        emit    = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_SKIP: begin
          if (skip_q != 2'd0) begin
            skip_d = skip_q - 2'd1;
          end
          if (skip_q <= 2'd1) begin
            phase_d = PH_CTRL;
          end
        end
        PH_CTRL: begin
          if (item_i.word[15:8] == LITERAL_TAG) begin
            run_d   = ~item_i.word + RUN_W'(1);
            phase_d = PH_LITERAL;
          end else begin
            run_d   = item_i.word;
            phase_d = PH_REPEAT;
          end
        end
        PH_REPEAT: begin
          phase_d = PH_CTRL;
          if (run_q != '0) begin
            emit   = 1'b1;
            emit_n = run_q;
            run_d  = '0;
          end
        end
        PH_LITERAL: begin
          if (run_q != '0) begin
            run_d = run_q - RUN_W'(1);
          end
          if (run_q <= RUN_W'(1)) begin
            phase_d = PH_CTRL;
          end
          emit = 1'b1;
        end
        PH_RAW: begin
          emit = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Clamp the run to the pixels still missing
    base      = item_i.start_req ? '0 : pixels_q;
    remaining = PIX_W'(IMAGE_PIXELS) - base;
    if (CMP_W'(emit_n) > CMP_W'(remaining)) begin
      clamp_n = CMP_W'(remaining);
    end else begin
      clamp_n = CMP_W'(emit_n);
    end
    done_next = base + PIX_W'(clamp_n);
    last      = (done_next == PIX_W'(IMAGE_PIXELS));

    pixels_d = base;
    if (emit) begin
      pixels_d = done_next;
      if (last) begin
        phase_d = PH_DONE;
      end
    end
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      skip_q      <= 2'd0;
      run_q       <= '0;
      pixels_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q  <= phase_d;
        skip_q   <= skip_d;
        run_q    <= run_d;
        pixels_q <= pixels_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      color_q <= to_argb(item_i.word);
      count_q <= COUNT_W'(clamp_n);
      last_q  <= last;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.color = color_q;
  assign out_o.count = count_q;
  assign out_o.last  = last_q;

endmodule

// File: rtl/core/rle_texture_rgb555_decoder.sv
// A texture word is held in the input register, then its run in the result register.
// Throughput: one texture word per cycle while the result port is not stalled; at most one run per word.
// A stalled result port holds the run; one more word waits in the input register.
// The input-to-result path is set by the clamp adder and compare in the decode stage.
// Reset (rst_ni low, asynchronous): decoder idle, counters zero, compressed mode off.
// Pipeline valids clear at reset; no memories, so no clearing pass.
module rle_texture_rgb555_decoder import rtd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  rtd_in_if.sink                in_i,
  rtd_out_if.source             out_o
);

  logic      compressed_mode;
  logic      advance;
  rtd_item_t item;

  rtd_cfg u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .compressed_mode_o (compressed_mode)
  );

  rtd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .item_o    (item)
  );

  rtd_decode u_decode (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .compressed_mode_i (compressed_mode),
    .item_i            (item),
    .advance_o         (advance),
    .out_o             (out_o)
  );

endmodule

// File: rtl/core/rtd_checker.sv
// Port-level checks for the texture decoder, attached to the top level by bind.
module rtd_checker import rtd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rtd_in_if.sink    in_mon,
  rtd_out_if.source out_mon
);

  // Stalled run holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mon.valid && !out_mon.ready |=>
      out_mon.valid && $stable(out_mon.color) && $stable(out_mon.count)
      && $stable(out_mon.last))
    else $error("result changed or dropped while stalled");

  // Input side never waits while the result register is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_mon.valid |-> in_mon.ready)
    else $error("input stalled with empty result register");

  // Runs are opaque and non-empty
  a_run_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mon.valid |-> (out_mon.color[31:24] == ALPHA_OPAQUE) && (out_mon.count != '0))
    else $error("run with wrong alpha or zero count");

  // A run never exceeds the image
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mon.valid |-> (32'(out_mon.count) <= 32'(IMAGE_PIXELS)))
    else $error("run longer than the image");

endmodule

bind rle_texture_rgb555_decoder rtd_checker u_rtd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .in_mon  (in_i),
  .out_mon (out_o)
);

// File: dv/tb_rle_texture_rgb555_decoder.sv
// Self-checking testbench for the RLE RGB555 texture decoder: predicted runs vs. DUT output.
module tb_rle_texture_rgb555_decoder;
  import rtd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_LIMIT   = 10;
  localparam int TARGET_WORDS   = 880;

  typedef struct packed {
    logic              start_req;
    logic [WORD_W-1:0] word;
  } tex_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
    logic               last;
  } pixel_run_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rtd_in_if  in_if ();
  rtd_out_if out_if ();

  rle_texture_rgb555_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // Word stream waiting to be sent and runs waiting to be seen
  tex_word_t  pending_words[$];
  pixel_run_t expected_runs[$];
  int         words_pushed;
  int         words_taken;
  int         mismatches;
  int         word_gap;
  int         stall_left;
  int         quiet_cycles;
  bit         send_idle_on;
  bit         recv_idle_on;

  // Decoder shadow state
  bit               mode_cfg;
  phase_e           dec_phase;
  logic [1:0]       skip_left;
  logic [RUN_W-1:0] run_left;
  logic [14:0]      pix_done;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return WORD_W'($urandom);
  endfunction

  // Clamp the run to the pixels still missing and account for it
  function automatic void emit_run(input logic [WORD_W-1:0] w, input int unsigned n,
                                   output pixel_run_t r);
    int unsigned remaining;
    remaining = IMAGE_PIXELS - int'(pix_done);
    if (n > remaining) n = remaining;
    pix_done = pix_done + 15'(n);
    r.color  = 32'hFF00_0000 | (32'(w[14:10]) << 19) | (32'(w[9:5]) << 11)
             | (32'(w[4:0]) << 3);
    r.count  = COUNT_W'(n);
    r.last   = (int'(pix_done) >= IMAGE_PIXELS);
    if (r.last) dec_phase = PH_DONE;
  endfunction

  // Advance the shadow decoder by one word; return 1 when a run comes out
  function automatic bit decode_word(input tex_word_t t, output pixel_run_t r);
    r = '0;
    if (t.start_req) begin
      pix_done = '0;
      run_left = '0;
      if (mode_cfg) begin
        skip_left = 2'd1;
        dec_phase = PH_SKIP;
        return 1'b0;
      end
      skip_left = '0;
      dec_phase = PH_RAW;
      emit_run(t.word, 1, r);
      return 1'b1;
    end
    case (dec_phase)
      PH_SKIP: begin
        if (skip_left > 0) skip_left = skip_left - 2'd1;
        if (skip_left == 0) dec_phase = PH_CTRL;
        return 1'b0;
      end
      PH_CTRL: begin
        if (t.word[15:8] == LITERAL_TAG) begin
          run_left  = 16'h0 - t.word;
          dec_phase = PH_LITERAL;
        end else begin
          run_left  = t.word;
          dec_phase = PH_REPEAT;
        end
        return 1'b0;
      end
      PH_REPEAT: begin
        dec_phase = PH_CTRL;
        if (run_left == 0) return 1'b0;
        emit_run(t.word, run_left, r);
        run_left = '0;
        return 1'b1;
      end
      PH_LITERAL: begin
        if (run_left > 0) run_left = run_left - 1'b1;
        if (run_left == 0) dec_phase = PH_CTRL;
        emit_run(t.word, 1, r);
        return 1'b1;
      end
      PH_RAW: begin
        emit_run(t.word, 1, r);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Word driver: predict on each transaction, then present the next word
  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    tex_word_t  taken;
    tex_word_t  nxt;
    pixel_run_t run;
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.start_req <= 1'b0;
      in_if.word      <= '0;
      word_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken.start_req = in_if.start_req;
        taken.word      = in_if.word;
        words_taken++;
        if (decode_word(taken, run)) expected_runs.push_back(run);
      end
      if (!in_if.valid || in_if.ready) begin
        if (word_gap > 0) begin
          word_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          nxt = pending_words.pop_front();
          in_if.valid     <= 1'b1;
          in_if.start_req <= nxt.start_req;
          in_if.word      <= nxt.word;
          word_gap = send_idle_on ? pick_gap() : 0;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Run monitor: compare each transaction with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : run_monitor
    pixel_run_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected run: color %h count %0d last %b",
                     out_if.color, out_if.count, out_if.last);
        end else begin
          want = expected_runs.pop_front();
          if (out_if.color !== want.color || out_if.count !== want.count ||
              out_if.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("run mismatch: exp color %h count %0d last %b, got %h %0d %b",
                       want.color, want.count, want.last,
                       out_if.color, out_if.count, out_if.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = recv_idle_on ? pick_gap() : 0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_word(input bit st, input logic [WORD_W-1:0] w);
    tex_word_t t;
    t.start_req = st;
    t.word      = w;
    pending_words.push_back(t);
    words_pushed++;
  endtask

  // Write the mode register through a setup and an access phase
  task automatic write_mode(input bit m);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_COMPRESSED_MODE;
    pwdata  <= APB_DATA_W'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mode_cfg = m;
  endtask

  // Wait until every word is taken and every run has arrived, then let the pipe settle
  task automatic drain_decoder();
    while (words_taken != words_pushed || expected_runs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Coded image: start, size word, then mostly well-formed control/colour groups
  task automatic push_rle_image(input int tokens);
    int          kind;
    int          len;
    logic [15:0] ctrl;
    push_word(1'b1, rand_word());
    push_word(1'b0, rand_word());
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        push_word(1'b0, 16'($urandom_range(0, 40)));
        push_word(1'b0, rand_word());
      end else if (kind < 50) begin
        push_word(1'b0, 16'($urandom_range(256, (kind < 49) ? 4000 : 16'hFEFF)));
        push_word(1'b0, rand_word());
      end else if (kind < 85) begin
        len = $urandom_range(1, 8);
        push_word(1'b0, 16'h0 - 16'(len));
        repeat (len) push_word(1'b0, rand_word());
      end else if (kind < 88) begin
        ctrl = {LITERAL_TAG, 8'($urandom)};
        push_word(1'b0, ctrl);
        len = int'(16'h0 - ctrl);
        repeat (len) push_word(1'b0, rand_word());
      end else if (kind < 96) begin
        push_word(1'b0, rand_word());
      end else begin
        push_word(1'b1, rand_word());
      end
    end
  endtask

  initial begin : stimulus
    int  phase_idx;
    bit  m;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_if.valid     = 1'b0;
    in_if.start_req = 1'b0;
    in_if.word      = '0;
    out_if.ready    = 1'b0;
    words_pushed    = 0;
    words_taken     = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    send_idle_on    = 1'b0;
    recv_idle_on    = 1'b0;
    mode_cfg        = 1'b0;
    dec_phase       = PH_IDLE;
    skip_left       = '0;
    run_left        = '0;
    pix_done        = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: raw words, word before any start, bit 15 dropped
    write_mode(1'b0);
    push_word(1'b0, 16'h1234);
    push_word(1'b1, 16'h0000);
    push_word(1'b0, 16'hFFFF);
    push_word(1'b0, 16'h8000);
    push_word(1'b0, 16'h7C00);
    drain_decoder();

    // Directed: mode flips mid-image, coded image with every kind of control word
    write_mode(1'b1);
    push_word(1'b0, 16'h001F);
    push_word(1'b1, 16'hABCD);
    push_word(1'b0, 16'h5678);
    push_word(1'b0, 16'h0003);
    push_word(1'b0, 16'h7FFF);
    push_word(1'b0, 16'h0000);
    push_word(1'b0, 16'h1234);
    push_word(1'b0, 16'hFFFE);
    push_word(1'b0, 16'h0421);
    push_word(1'b0, 16'hFBDE);
    push_word(1'b0, 16'hFFFF);
    push_word(1'b0, 16'h2108);
    // Overlong repeat: clamp to the end of the image, then ignore the tail
    push_word(1'b0, 16'hFEFF);
    push_word(1'b0, 16'h4210);
    push_word(1'b0, 16'h0005);
    // Restart while a repeat is pending
    push_word(1'b1, 16'h1111);
    push_word(1'b0, 16'h2222);
    push_word(1'b0, 16'h0002);
    push_word(1'b1, 16'h0033);
    push_word(1'b0, 16'h0044);
    push_word(1'b0, 16'hFF00);
    drain_decoder();

    // Random phases: new mode, new idle pattern, one or more images
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    phase_idx    = 0;
    while (words_pushed < TARGET_WORDS) begin
      m = (phase_idx < 2) ? !phase_idx[0] : bit'($urandom_range(0, 1));
      write_mode(m);
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      // Sometimes carry on the old image under the new mode
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6)) push_word(1'b0, rand_word());
      repeat ($urandom_range(1, 3)) begin
        // Stop adding images once the word budget is reached
        if (words_pushed < TARGET_WORDS) begin
          if (m) begin
            push_rle_image($urandom_range(5, 40));
          end else begin
            push_word(1'b1, rand_word());
            repeat ($urandom_range(10, 60))
              push_word($urandom_range(0, 19) == 0, rand_word());
          end
        end
      end
      drain_decoder();
      phase_idx++;
    end

    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
